/* src/rolling_hash_pattern_matcher_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rolling hash pattern matcher
// Implication checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH
`define ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RHPM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhpm: same-cycle check failed");

// next-cycle implication
`define RHPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhpm: next-cycle check failed");

`else

`define RHPM_ASSERT_IMP(label, ante, cons)
`define RHPM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/rhpm_pkg.sv */
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared constants, register map, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rhpm_pkg;

	localparam int DEF_MAX_PATTERN = 8;
	localparam int DEF_HASH_WIDTH  = 16;

	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 32;
	localparam int PAT_W      = 64;
	localparam int LEN_W      = 4;
	localparam int MOD_W      = 16;
	localparam int HASH_OUT_W = 16;
	localparam int SEL_W      = 3;   // bit / byte select inside the pattern word

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;

	localparam logic [IDX_W-1:0] INDEX_MAX = '1;
	localparam logic [SEL_W-1:0] BIT_MSB   = 3'd7;

	localparam logic [PAT_W-1:0] PATTERN_RST = '0;
	localparam logic [LEN_W-1:0] LENGTH_RST  = 4'd3;
	localparam logic [MOD_W-1:0] MODULUS_RST = 16'd101;

	// register index = paddr[4:3]
	localparam logic [1:0] REG_PATTERN = 2'd0;
	localparam logic [1:0] REG_LENGTH  = 2'd1;
	localparam logic [1:0] REG_MODULUS = 2'd2;

	typedef enum logic [2:0] {
		ST_DERIVE_INIT,
		ST_DERIVE,
		ST_IDLE,
		ST_SUB,
		ST_SUB_APPLY,
		ST_SHIFT_IN,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_DERIVE,
		OP_CAPTURE,
		OP_SUB,
		OP_SUB_APPLY,
		OP_SHIFT_IN,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SEL_W-1:0] bit_sel;
		logic [SEL_W-1:0] byte_sel;
		logic             lp_en;
	} cmd_t;

	typedef struct packed {
		logic             take_sub;  // window full and no restart on this beat
		logic             out_free;  // output register can load this cycle
		logic [SEL_W-1:0] len_m1;    // effective pattern length minus one
	} sts_t;

endpackage

`default_nettype wire

/* src/rhpm_ctrl.sv */
// ----------------------------------------------------------------------------
// rhpm_ctrl
// Sequencer: pattern hash derivation after reset or a register write, then
// per beat the remove-old-byte multiply and subtract (full window only), the shift-in.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpm_ctrl import rhpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q, state_d;
	logic [SEL_W-1:0] bit_q;
	logic [SEL_W-1:0] byte_q;
	logic             last_bit;

	assign last_bit = (bit_q == BIT_MSB);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_DERIVE_INIT: state_d = ST_DERIVE;
			ST_DERIVE: begin
				if (last_bit && byte_q == sts.len_m1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = sts.take_sub ? ST_SUB : ST_SHIFT_IN;
			end
			ST_SUB: begin
				if (last_bit) state_d = ST_SUB_APPLY;
			end
			ST_SUB_APPLY: state_d = ST_SHIFT_IN;
			ST_SHIFT_IN: begin
				if (last_bit) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_DERIVE_INIT;
		endcase
		if (cfg_write) state_d = ST_DERIVE_INIT;
	end

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.bit_sel  = BIT_MSB - bit_q;   // MSB first
		cmd.byte_sel = byte_q;
		cmd.lp_en    = (byte_q != '0);
		in_ready     = 1'b0;
		case (state_q)
			ST_DERIVE_INIT: cmd.op = OP_INIT;
			ST_DERIVE:      cmd.op = OP_DERIVE;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_CAPTURE;
			end
			ST_SUB:       cmd.op = OP_SUB;
			ST_SUB_APPLY: cmd.op = OP_SUB_APPLY;
			ST_SHIFT_IN:  cmd.op = OP_SHIFT_IN;
			ST_FINISH: begin
				if (sts.out_free) cmd.op = OP_COMMIT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DERIVE_INIT;
			bit_q   <= '0;
			byte_q  <= '0;
		end else begin
			state_q <= state_d;
			if (!cfg_write && (state_q inside {ST_SUB, ST_SHIFT_IN, ST_DERIVE}))
				bit_q <= bit_q + 1'b1;
			else
				bit_q <= '0;
			if (state_q == ST_DERIVE_INIT)
				byte_q <= '0;
			else if (state_q == ST_DERIVE && last_bit)
				byte_q <= byte_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* src/rhpm_datapath.sv */
// ----------------------------------------------------------------------------
// rhpm_datapath
// Window shift line, rolling hash, bit-serial modular multiply/reduce,
// window compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rolling_hash_pattern_matcher_assert.svh"

module rhpm_datapath import rhpm_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int HASH_WIDTH  = DEF_HASH_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_write,
	input  logic [PAT_W-1:0]      pat_bytes,
	input  logic [LEN_W-1:0]      pat_len,
	input  logic [MOD_W-1:0]      modulus,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  start_of_text,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  match_found,
	output logic [IDX_W-1:0]      match_start,
	output logic                  window_full,
	output logic [HASH_OUT_W-1:0] text_hash,
	output logic [HASH_OUT_W-1:0] pattern_hash
);

	localparam int HW = HASH_WIDTH;
	localparam int QW = (HASH_WIDTH < MOD_W) ? HASH_WIDTH : MOD_W;
	localparam int FW = $clog2(MAX_PATTERN + 1);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// (2a + b) mod m, a < m
	function automatic logic [HW-1:0] mod_dbl(input logic [HW-1:0] a, input logic b,
			input logic [HW-1:0] m);
		logic [HW:0] s;
		s = {a, b};
		mod_dbl = (s >= {1'b0, m}) ? HW'(s - {1'b0, m}) : HW'(s);
	endfunction

	// (a + b) mod m, a, b < m
	function automatic logic [HW-1:0] mod_add(input logic [HW-1:0] a, input logic [HW-1:0] b,
			input logic [HW-1:0] m);
		logic [HW:0] s;
		s = {1'b0, a} + {1'b0, b};
		mod_add = (s >= {1'b0, m}) ? HW'(s - {1'b0, m}) : HW'(s);
	endfunction

	logic [BYTE_W-1:0] win_q [MAX_PATTERN];
	logic [BYTE_W-1:0] win_next [MAX_PATTERN];
	logic [FW-1:0]     fill_q, fill_next;
	logic [HW-1:0]     hash_q, ph_q, lp_q, acc_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] tb_q;
	logic              out_valid_q, match_q, full_q;
	logic [IDX_W-1:0]  start_q;
	logic [HASH_OUT_W-1:0] th_q, ph_out_q;

	logic [HW-1:0]     q;
	logic [FW-1:0]     len;
	logic [SEL_W-1:0]  len_m1;
	logic              full_pre, full_new, bytes_eq, hit;
	logic [BYTE_W-1:0] old_byte;
	logic [SEL_W-1:0]  pj;
	logic [IDX_W-1:0]  acc_wide, ph_wide;

	// effective modulus and length
	always_comb begin
		q = HW'(modulus[QW-1:0]);
		if (q < HW'(2)) q = HW'(2);
		if (pat_len == '0)
			len = FW'(1);
		else if (pat_len > LEN_W'(MAX_PATTERN))
			len = FW'(MAX_PATTERN);
		else
			len = FW'(pat_len);
	end

	assign len_m1   = SEL_W'(len - 1'b1);
	assign full_pre = (fill_q >= len);
	assign old_byte = win_q[len_m1[IW-1:0]];

	assign sts.take_sub = full_pre && !start_of_text;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.len_m1   = len_m1;

	// window after this beat's byte, and the exact compare against the pattern
	always_comb begin
		win_next[0] = tb_q;
		for (int i = 1; i < MAX_PATTERN; i++) win_next[i] = win_q[i-1];
		bytes_eq = 1'b1;
		pj       = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pj = len_m1 - SEL_W'(i);
			if (FW'(i) < len && win_next[i] != pat_bytes[{pj, 3'b000} +: BYTE_W])
				bytes_eq = 1'b0;
		end
	end

	assign fill_next = (fill_q < len) ? fill_q + 1'b1 : fill_q;
	assign full_new  = (fill_next >= len);
	assign hit       = full_new && (acc_q == ph_q) && bytes_eq;
	assign acc_wide  = IDX_W'(acc_q);
	assign ph_wide   = IDX_W'(ph_q);

	// arithmetic and output payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT: begin
				ph_q <= '0;
				lp_q <= HW'(1);
			end
			OP_DERIVE: begin
				ph_q <= mod_dbl(ph_q, pat_bytes[{cmd.byte_sel, cmd.bit_sel}], q);
				if (cmd.lp_en) lp_q <= mod_dbl(lp_q, 1'b0, q);
			end
			OP_CAPTURE: begin
				tb_q  <= text_byte;
				acc_q <= (!start_of_text && !full_pre) ? hash_q : '0;
			end
			OP_SUB: begin
				acc_q <= mod_add(mod_dbl(acc_q, 1'b0, q),
					old_byte[cmd.bit_sel] ? lp_q : '0, q);
			end
			OP_SUB_APPLY: begin
				acc_q <= (hash_q >= acc_q) ? hash_q - acc_q : hash_q - acc_q + q;
			end
			OP_SHIFT_IN: acc_q <= mod_dbl(acc_q, tb_q[cmd.bit_sel], q);
			OP_COMMIT: begin
				match_q  <= hit;
				full_q   <= full_new;
				start_q  <= full_new ? idx_q - IDX_W'(len_m1) : '0;
				th_q     <= acc_wide[HASH_OUT_W-1:0];
				ph_out_q <= ph_wide[HASH_OUT_W-1:0];
			end
			default: ;
		endcase
	end

	// window, fill, hash and index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) win_q[i] <= '0;
			fill_q <= '0;
			hash_q <= '0;
			idx_q  <= '0;
		end else if (cfg_write || (cmd.op == OP_CAPTURE && start_of_text)) begin
			for (int i = 0; i < MAX_PATTERN; i++) win_q[i] <= '0;
			fill_q <= '0;
			hash_q <= '0;
			idx_q  <= '0;
		end else if (cmd.op == OP_COMMIT) begin
			for (int i = 0; i < MAX_PATTERN; i++) win_q[i] <= win_next[i];
			fill_q <= fill_next;
			hash_q <= acc_q;
			if (idx_q != INDEX_MAX) idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_COMMIT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid    = out_valid_q;
	assign match_found  = match_q;
	assign match_start  = start_q;
	assign window_full  = full_q;
	assign text_hash    = th_q;
	assign pattern_hash = ph_out_q;

	`RHPM_ASSERT_IMP(a_hash_reduced, 1'b1, hash_q < q)
	`RHPM_ASSERT_IMP(a_commit_slot_free, cmd.op == OP_COMMIT, !out_valid_q || out_ready)
	`RHPM_ASSERT_NEXT(a_commit_shows_beat, cmd.op == OP_COMMIT, out_valid_q)
	`RHPM_ASSERT_IMP(a_match_needs_full, out_valid_q && match_q, full_q)

endmodule

`default_nettype wire

/* src/rolling_hash_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher
// Streaming Rabin-Karp matcher: rolling base-256 hash over the last
// pattern_length text bytes, exact window check on a hash hit.
// ----------------------------------------------------------------------------
// Every accepted text beat gives one result beat. A beat that lands while the
// window is still filling goes from the accept through 8 shift-in steps to
// the commit into the result register; once the window is full it goes
// through the accept, 8 steps of the serial multiply that takes the oldest
// byte out of the hash, one modular subtract, 8 shift-in steps and the commit.
// The steps run bit-serially in the datapath's modular add/double logic, one
// bit of a byte per cycle. in_ready is high only between beats; a finished
// result sits in the output register and does not hold up the next beat, but
// a commit waits while an earlier result is still unread. After reset and
// after every write to a mapped register the block hashes the pattern bit by
// bit over the effective pattern length, with in_ready low; a write also
// clears the window, hash and byte index, as start_of_text does.
// Registers sit on an APB-style port at paddr 0 (pattern_bytes, 64 bit),
// 8 (pattern_length) and 16 (hash_modulus). pattern_length 0 acts as 1 and
// values above MAX_PATTERN as MAX_PATTERN; hash_modulus 0 or 1 acts as 2.
// The byte index saturates at all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_hash_pattern_matcher import rhpm_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int HASH_WIDTH  = DEF_HASH_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// text beats
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  start_of_text,
	// result beats
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  match_found,
	output logic [IDX_W-1:0]      match_start,
	output logic                  window_full,
	output logic [HASH_OUT_W-1:0] text_hash,
	output logic [HASH_OUT_W-1:0] pattern_hash
);

	logic [PAT_W-1:0] pattern_q;
	logic [LEN_W-1:0] length_q;
	logic [MOD_W-1:0] modulus_q;
	logic             apb_wr, cfg_write;
	logic [1:0]       reg_sel;
	cmd_t             cmd;
	sts_t             sts;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[4:3];

	// a write to an unmapped index does nothing, not even a restart
	always_comb begin
		case (reg_sel)
			REG_PATTERN, REG_LENGTH, REG_MODULUS: cfg_write = apb_wr;
			default:                              cfg_write = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RST;
			length_q  <= LENGTH_RST;
			modulus_q <= MODULUS_RST;
		end else if (apb_wr) begin
			case (reg_sel)
				REG_PATTERN: pattern_q <= pwdata;
				REG_LENGTH:  length_q  <= pwdata[LEN_W-1:0];
				REG_MODULUS: modulus_q <= pwdata[MOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PATTERN: prdata = pattern_q;
			REG_LENGTH:  prdata = APB_DATA_W'(length_q);
			REG_MODULUS: prdata = APB_DATA_W'(modulus_q);
			default:     prdata = '0;
		endcase
	end

	rhpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rhpm_datapath #(
		.MAX_PATTERN (MAX_PATTERN),
		.HASH_WIDTH  (HASH_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.pat_bytes     (pattern_q),
		.pat_len       (length_q),
		.modulus       (modulus_q),
		.text_byte     (text_byte),
		.start_of_text (start_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_found   (match_found),
		.match_start   (match_start),
		.window_full   (window_full),
		.text_hash     (text_hash),
		.pattern_hash  (pattern_hash)
	);

endmodule

`default_nettype wire

/* tb/sv/rolling_hash_pattern_matcher_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher_test
// Self-checking bench for the streaming Rabin-Karp matcher. A scoreboard
// class keeps its own rolling hash, window and index and predicts one result
// beat per accepted text beat. Plain tasks drive the text channel and the
// APB-style register port. A directed part hits the clamps, restarts and
// full-range bytes, then random phases stream text seeded with pattern copies
// under a fresh register setting each.
// ----------------------------------------------------------------------------

module rolling_hash_pattern_matcher_test;
	import rhpm_pkg::*;

	// index 3 decodes to no register; a write there must change nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_BEATS   = 96;

	typedef struct packed {
		logic                  found;
		logic [IDX_W-1:0]      start;
		logic                  full;
		logic [HASH_OUT_W-1:0] thash;
		logic [HASH_OUT_W-1:0] phash;
	} match_beat_t;

	// ------------------------------------------------------------------------
	// Scoreboard: rolling hash predictor plus the queue of pending results
	// ------------------------------------------------------------------------
	class match_scoreboard;
		logic [PAT_W-1:0]  pat_bytes;
		logic [LEN_W-1:0]  pat_len;
		logic [MOD_W-1:0]  modulus;
		logic [BYTE_W-1:0] window [DEF_MAX_PATTERN];   // newest at 0
		int unsigned       fill;
		int unsigned       win_hash;
		int unsigned       pat_hash;
		int unsigned       lead_pow;
		logic [IDX_W-1:0]  next_index;
		match_beat_t       expected [$];
		int                errors;

		function new();
			pat_bytes = PATTERN_RST;
			pat_len   = LENGTH_RST;
			modulus   = MODULUS_RST;
			errors    = 0;
			rederive();
			clear();
		endfunction

		function int unsigned eff_len();
			if (pat_len == 0)
				return 1;
			if (pat_len > DEF_MAX_PATTERN)
				return DEF_MAX_PATTERN;
			return 32'(pat_len);
		endfunction

		function int unsigned eff_mod();
			return (modulus < 2) ? 2 : 32'(modulus);
		endfunction

		function void clear();
			foreach (window[i])
				window[i] = '0;
			fill       = 0;
			win_hash   = 0;
			next_index = '0;
		endfunction

		// pattern hash and 256^(L-1) mod Q
		function void rederive();
			int unsigned len;
			int unsigned q;
			len      = eff_len();
			q        = eff_mod();
			pat_hash = 0;
			lead_pow = 1;
			for (int j = 0; j < len; j++)
				pat_hash = (pat_hash * 256 + pat_bytes[8*j +: 8]) % q;
			for (int j = 1; j < len; j++)
				lead_pow = (lead_pow * 256) % q;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				REG_PATTERN: pat_bytes = value;
				REG_LENGTH:  pat_len   = value[LEN_W-1:0];
				REG_MODULUS: modulus   = value[MOD_W-1:0];
				default:     return;
			endcase
			rederive();
			clear();
		endfunction

		function logic [63:0] reg_value(logic [1:0] idx);
			case (idx)
				REG_PATTERN: return pat_bytes;
				REG_LENGTH:  return 64'(pat_len);
				REG_MODULUS: return 64'(modulus);
				default:     return '0;
			endcase
		endfunction

		function void note_text(logic [BYTE_W-1:0] ch, logic restart);
			int unsigned len;
			int unsigned q;
			int unsigned h;
			logic [IDX_W-1:0] cur;
			match_beat_t beat;
			len = eff_len();
			q   = eff_mod();
			if (restart)
				clear();
			h = win_hash % q;
			// roll the oldest byte out once the window is full
			if (fill >= len)
				h = (h + q - (window[len-1] * lead_pow) % q) % q;
			h = (h * 256 + ch) % q;
			win_hash = h;
			for (int j = DEF_MAX_PATTERN - 1; j > 0; j--)
				window[j] = window[j-1];
			window[0] = ch;
			if (fill < len)
				fill++;
			cur = next_index;
			if (next_index != INDEX_MAX)
				next_index++;
			beat.full  = (fill >= len);
			beat.found = 1'b0;
			if (beat.full && h == pat_hash) begin
				beat.found = 1'b1;
				for (int j = 0; j < len; j++)
					if (window[len-1-j] != pat_bytes[8*j +: 8])
						beat.found = 1'b0;
			end
			beat.start = beat.full ? cur - IDX_W'(len - 1) : '0;
			beat.thash = h[HASH_OUT_W-1:0];
			beat.phash = pat_hash[HASH_OUT_W-1:0];
			expected.push_back(beat);
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			errors++;
			$display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
		endtask

		task check(match_beat_t got);
			match_beat_t want;
			if (expected.size() == 0) begin
				report_mismatch("result beat with nothing pending", 0, 0);
				return;
			end
			want = expected.pop_front();
			if (got.found !== want.found)
				report_mismatch("match_found", got.found, want.found);
			if (got.start !== want.start)
				report_mismatch("match_start", got.start, want.start);
			if (got.full !== want.full)
				report_mismatch("window_full", got.full, want.full);
			if (got.thash !== want.thash)
				report_mismatch("text_hash", got.thash, want.thash);
			if (got.phash !== want.phash)
				report_mismatch("pattern_hash", got.phash, want.phash);
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic [BYTE_W-1:0]     text_byte;
	logic                  start_of_text;
	logic                  out_valid;
	logic                  out_ready;
	logic                  match_found;
	logic [IDX_W-1:0]      match_start;
	logic                  window_full;
	logic [HASH_OUT_W-1:0] text_hash;
	logic [HASH_OUT_W-1:0] pattern_hash;

	match_scoreboard sb = new();
	bit              calm = 1'b0;      // last phase: no stalls on either side
	int unsigned     cycle_count = 0;

	rolling_hash_pattern_matcher u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.start_of_text (start_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_found   (match_found),
		.match_start   (match_start),
		.window_full   (window_full),
		.text_hash     (text_hash),
		.pattern_hash  (pattern_hash)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rolling_hash_pattern_matcher_test failed");
			$finish;
		end
	end

	// Result side. Reads at the edge see pre-edge values, since every driver
	// here and in the block updates through nonblocking assignments.
	always @(posedge clk) begin : result_monitor
		match_beat_t got;
		if (arst_n && out_valid && out_ready) begin
			got.found = match_found;
			got.start = match_start;
			got.full  = window_full;
			got.thash = text_hash;
			got.phash = pattern_hash;
			sb.check(got);
		end
	end

	// Sink pacing: random stall bursts between ready stretches.
	initial begin : sink_pacing
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers. Each task is entered right after a rising edge and returns
	// right after the edge that finished its transfer.
	// ------------------------------------------------------------------------

	// One text beat. Valid stays up across back-to-back beats; an idle burst
	// lands either at once (block still busy) or after in_ready has risen.
	task automatic send_text(input logic [BYTE_W-1:0] ch, input logic restart);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 1)) begin
				@(posedge clk);
				while (!in_ready)
					@(posedge clk);
			end
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		text_byte     <= ch;
		start_of_text <= restart;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_text(ch, restart);
	endtask

	// drop valid and let every pending result drain
	task automatic stop_text();
		in_valid <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Register write, read back, then wait out the pattern hashing pass
	// (in_ready stays low until it is done).
	task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, value);
		if (idx != REG_UNUSED) begin
			// straight into the read setup, psel stays up
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			if (prdata !== sb.reg_value(idx))
				sb.report_mismatch("register readback", prdata, sb.reg_value(idx));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// mostly pattern characters so hash hits and near misses are common
	function automatic logic [BYTE_W-1:0] pick_text(logic [PAT_W-1:0] pat, int unsigned len);
		if ($urandom_range(0, 9) < 6)
			return pat[8*$urandom_range(0, len - 1) +: 8];
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [PAT_W-1:0]  pat;
		logic [63:0]       len_word;
		logic [63:0]       mod_word;
		logic [BYTE_W-1:0] ch;
		int unsigned       plen;
		int unsigned       sent;
		int unsigned       pos;
		bit                corrupt;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		text_byte     = '0;
		start_of_text = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// pattern hashing pass after reset
		while (!in_ready)
			@(posedge clk);

		// reset setting: zero pattern, length 3, modulus 101 -> zeros match
		send_text(8'h00, 1'b1);
		send_text(8'h00, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'hFF, 1'b0);
		send_text(8'h00, 1'b0);
		stop_text();

		// "abc" with junk above the used bytes; restart mid-stream
		reg_write(REG_PATTERN, 64'hA5A5_A5A5_A563_6261);
		send_text("x", 1'b1);
		send_text("a", 1'b0);
		send_text("b", 1'b0);
		send_text("c", 1'b0);
		send_text("a", 1'b1);
		send_text("b", 1'b0);
		send_text("c", 1'b0);
		stop_text();

		// length 0 acts as 1, modulus 1 and then 0 act as 2: hash hits galore
		reg_write(REG_PATTERN, 64'h0000_0000_0000_0080);
		reg_write(REG_LENGTH, 64'h0);
		reg_write(REG_MODULUS, 64'h1);
		send_text(8'h80, 1'b1);
		send_text(8'h7F, 1'b0);
		send_text(8'h80, 1'b0);
		send_text(8'h00, 1'b0);
		stop_text();
		reg_write(REG_MODULUS, 64'h0);
		send_text(8'h01, 1'b0);
		send_text(8'h80, 1'b0);
		stop_text();

		// length 15 clamps to 8, largest modulus, all-ones pattern
		reg_write(REG_PATTERN, '1);
		reg_write(REG_LENGTH, 64'hF);
		reg_write(REG_MODULUS, 64'hFFFF);
		repeat (9) send_text(8'hFF, 1'b0);
		stop_text();

		// write to a hole in the map: no effect on the running window
		reg_write(REG_UNUSED, 64'hDEAD_BEEF_0123_4567);
		send_text(8'hFF, 1'b0);
		stop_text();

		// random phases, each under a fresh setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if ($urandom_range(0, 1))
				pat = {$urandom, $urandom};
			else
				for (int j = 0; j < 8; j++)
					pat[8*j +: 8] = BYTE_W'("a" + $urandom_range(0, 3));

			if ($urandom_range(0, 9) == 0)
				len_word = ($urandom_range(0, 1)) ? 64'd0 : 64'($urandom_range(9, 15));
			else
				len_word = 64'($urandom_range(1, 8));

			case ($urandom_range(0, 9))
				0:       mod_word = 64'd0;
				1:       mod_word = 64'd1;
				2:       mod_word = 64'd2;
				3:       mod_word = 64'd3;
				4:       mod_word = 64'd101;
				5:       mod_word = 64'd257;
				6:       mod_word = 64'd65521;
				7:       mod_word = 64'd65535;
				default: mod_word = 64'($urandom_range(2, 65535));
			endcase

			// junk above the register width is dropped by the block
			if ($urandom_range(0, 3) == 0) begin
				len_word |= {$urandom, $urandom} << LEN_W;
				mod_word |= {$urandom, $urandom} << MOD_W;
			end

			reg_write(REG_PATTERN, pat);
			reg_write(REG_LENGTH, len_word);
			reg_write(REG_MODULUS, mod_word);
			if ($urandom_range(0, 3) == 0)
				reg_write(REG_UNUSED, {$urandom, $urandom});

			calm = (phase == RANDOM_PHASES - 1);
			plen = sb.eff_len();
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(0, 9) < 3) begin
					// a pattern copy, sometimes with one flipped bit
					corrupt = ($urandom_range(0, 2) == 0);
					pos     = $urandom_range(0, plen - 1);
					for (int j = 0; j < plen; j++) begin
						ch = pat[8*j +: 8];
						if (corrupt && j == pos)
							ch ^= 8'h01 << $urandom_range(0, 7);
						send_text(ch, 1'b0);
					end
					sent += plen;
				end else begin
					send_text(pick_text(pat, plen), $urandom_range(0, 39) == 0);
					sent++;
				end
			end
			stop_text();
		end

		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("rolling_hash_pattern_matcher_test passed");
		else
			$display("rolling_hash_pattern_matcher_test failed");
		$finish;
	end

endmodule
